### sv/lice_pkg.sv
// Shared types and constants for the LR(0) item closure engine.
// Depends on nothing; used by lice_sym_store and lr0_item_closure_engine_unit.
package lice_pkg;

	localparam int unsigned RULES  = 32;
	localparam int unsigned RIDX_W = 5;
	localparam int unsigned RLEN   = 8;
	localparam int unsigned DOT_W  = 3;
	localparam int unsigned LEN_W  = 4;
	localparam int unsigned ROW_W  = 9;
	localparam int unsigned SYM_W  = 6;
	localparam int unsigned SYMS   = 64;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned ADDR_W = RIDX_W + DOT_W;

	typedef enum logic [2:0] {
		F_HEAD  = 3'd0,
		F_SYM   = 3'd1,
		F_CLEAR = 3'd2,
		F_ADD   = 3'd3,
		F_INIT  = 3'd4,
		F_CLOSE = 3'd5,
		F_GOTO  = 3'd6,
		F_QUERY = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		R_ACK  = 2'd0,
		R_ROW  = 2'd1,
		R_MASK = 2'd2
	} reply_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_ADD,
		S_ROWS,
		S_REPLY
	} state_t;

	typedef enum logic {
		C_RULE_COUNT = 1'b0,
		C_TERM_COUNT = 1'b1
	} cfg_t;

endpackage

### sv/lice_sym_store.sv
// Right-hand symbol store: one write port, one registered read port.
// Depends on lice_pkg.
module lice_sym_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [lice_pkg::ADDR_W-1:0] waddr,
	input  logic [lice_pkg::SYM_W-1:0]  wdata,
	input  logic [lice_pkg::ADDR_W-1:0] raddr,
	output logic [lice_pkg::SYM_W-1:0]  rdata
);

	logic [lice_pkg::SYM_W-1:0] mem [lice_pkg::RULES*lice_pkg::RLEN];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/lr0_item_closure_engine_unit.sv
// LR(0) item set engine: loads, clear, add, initial go through the reply state to the acknowledge word.
// Goto and symbol mask query: walk all (rule, dot) pairs, one symbol store read per cycle (n = rules in use).
// Close: each pass walks the pairs and then scans the n rows, at most n+1 passes.
// Row readout: one word per cycle while the output is not held, n words. One command is in work at a time.
// Reset (arst_n low) clears the item set, both registers and all control state.
module lr0_item_closure_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [4:0]                  rule_index,
	input  logic [3:0]                  position,
	input  logic [5:0]                  symbol,
	input  logic                        readout_kind,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  reply_kind,
	output logic [4:0]                  row_rule,
	output logic [8:0]                  dot_mask,
	output logic [63:0]                 symbol_mask,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [6:0]                  cfg_data
);

	// Configuration registers.
	logic [5:0] rc_q;
	logic [6:0] tc_q;

	// Grammar heads and the current item set.
	logic [lice_pkg::SYM_W-1:0] left_q [lice_pkg::RULES];
	logic [lice_pkg::LEN_W-1:0] len_q  [lice_pkg::RULES];
	logic [lice_pkg::ROW_W-1:0] rows_q [lice_pkg::RULES];

	lice_pkg::state_t state_q, state_d;
	lice_pkg::func_t  func_q;
	lice_pkg::reply_t rk_q;
	logic [lice_pkg::SYM_W-1:0] gsym_q;

	// Walk over (rule, dot) pairs: issue counter and one read stage.
	logic                        iss_q;
	logic [lice_pkg::ADDR_W-1:0] ia_q;
	logic                        v_s1;
	logic [lice_pkg::RIDX_W-1:0] r_s1;
	logic [lice_pkg::DOT_W-1:0]  d_s1;
	logic                        last_s1;
	logic [lice_pkg::SYM_W-1:0]  sym_rd;

	logic [lice_pkg::SYMS-1:0]  mask_q, want_q;
	logic [lice_pkg::ROW_W-1:0] mv_q;
	logic [lice_pkg::RIDX_W-1:0] ar_q;
	logic                        chg_q;

	logic                        out_valid_q;
	lice_pkg::reply_t            okind_q;
	logic [4:0]                  orow_q;
	logic [8:0]                  odots_q;
	logic [63:0]                 osyms_q;
	logic                        olast_q;

	logic [lice_pkg::CNT_W-1:0]  n;
	logic [lice_pkg::CNT_W-1:0]  n_m1;
	logic                        acc;
	logic                        out_free;
	logic                        out_load;
	logic                        last_iss;
	logic                        hit;
	logic [lice_pkg::SYMS-1:0]   mask_next;
	logic [lice_pkg::SYMS-1:0]   want_next;
	logic [lice_pkg::ROW_W-1:0]  mv_next;
	logic                        add_set;
	logic                        ar_last;
	logic                        sym_we;
	logic [lice_pkg::ADDR_W-1:0] sym_waddr;
	lice_pkg::func_t             fin;

	// Rules in use never exceed the table depth.
	assign n        = (rc_q > lice_pkg::CNT_W'(lice_pkg::RULES))
	                  ? lice_pkg::CNT_W'(lice_pkg::RULES) : rc_q;
	assign n_m1     = n - lice_pkg::CNT_W'(1);
	assign in_ready = (state_q == lice_pkg::S_IDLE);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	// A new reply word enters the output register in these states when it is free.
	assign out_load = out_free
	                  && ((state_q == lice_pkg::S_ROWS) || (state_q == lice_pkg::S_REPLY));
	assign fin      = lice_pkg::func_t'(func);
	assign last_iss = (ia_q == {n_m1[lice_pkg::RIDX_W-1:0], {lice_pkg::DOT_W{1'b1}}});

	assign sym_we    = acc && (fin == lice_pkg::F_SYM) && (position < 4'(lice_pkg::RLEN));
	assign sym_waddr = {rule_index, position[lice_pkg::DOT_W-1:0]};

	lice_sym_store u_store (
		.clk   (clk),
		.we    (sym_we),
		.waddr (sym_waddr),
		.wdata (symbol),
		.raddr (ia_q),
		.rdata (sym_rd)
	);

	// A dot counts only inside the rule; complete items never contribute.
	assign hit = v_s1 && (lice_pkg::LEN_W'(d_s1) < len_q[r_s1]) && rows_q[r_s1][d_s1];
	assign mask_next = mask_q | (hit ? (lice_pkg::SYMS'(1) << sym_rd) : '0);
	assign mv_next = mv_q | ((hit && (sym_rd == gsym_q))
	                 ? (lice_pkg::ROW_W'(1) << (lice_pkg::DOT_W+1)'({1'b0, d_s1} + 4'd1))
	                 : '0);

	// Keep only nonterminals: codes at or above the terminal count.
	always_comb begin
		for (int s = 0; s < int'(lice_pkg::SYMS); s++) begin
			want_next[s] = mask_next[s] && (7'(s) >= tc_q);
		end
	end

	assign add_set = want_q[left_q[ar_q]] && !rows_q[ar_q][0];
	assign ar_last = (ar_q == n_m1[lice_pkg::RIDX_W-1:0]);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lice_pkg::S_IDLE: begin
				if (acc) begin
					case (fin)
						lice_pkg::F_CLOSE, lice_pkg::F_GOTO: begin
							state_d = (n == '0) ? lice_pkg::S_REPLY : lice_pkg::S_WALK;
						end
						lice_pkg::F_QUERY: begin
							if (readout_kind) begin
								state_d = (n == '0) ? lice_pkg::S_REPLY : lice_pkg::S_ROWS;
							end else begin
								state_d = (n == '0) ? lice_pkg::S_REPLY : lice_pkg::S_WALK;
							end
						end
						default: state_d = lice_pkg::S_REPLY;
					endcase
				end
			end
			lice_pkg::S_WALK: begin
				if (v_s1 && last_s1) begin
					state_d = (func_q == lice_pkg::F_CLOSE) ? lice_pkg::S_ADD : lice_pkg::S_REPLY;
				end
			end
			lice_pkg::S_ADD: begin
				if (ar_last) begin
					state_d = (chg_q || add_set) ? lice_pkg::S_WALK : lice_pkg::S_REPLY;
				end
			end
			lice_pkg::S_ROWS: begin
				if (out_free && ar_last) begin
					state_d = lice_pkg::S_IDLE;
				end
			end
			lice_pkg::S_REPLY: begin
				if (out_free) begin
					state_d = lice_pkg::S_IDLE;
				end
			end
			default: state_d = lice_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lice_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Grammar heads carry no reset.
	always_ff @(posedge clk) begin
		if (acc && (fin == lice_pkg::F_HEAD)) begin
			left_q[rule_index] <= symbol;
			len_q[rule_index]  <= (position > 4'(lice_pkg::RLEN))
			                      ? lice_pkg::LEN_W'(lice_pkg::RLEN) : position;
		end
	end

	// Control, item set and walk datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q        <= '0;
			tc_q        <= '0;
			for (int r = 0; r < int'(lice_pkg::RULES); r++) begin
				rows_q[r] <= '0;
			end
			func_q      <= lice_pkg::F_HEAD;
			rk_q        <= lice_pkg::R_ACK;
			gsym_q      <= '0;
			iss_q       <= 1'b0;
			ia_q        <= '0;
			v_s1        <= 1'b0;
			r_s1        <= '0;
			d_s1        <= '0;
			last_s1     <= 1'b0;
			mask_q      <= '0;
			want_q      <= '0;
			mv_q        <= '0;
			ar_q        <= '0;
			chg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			okind_q     <= lice_pkg::R_ACK;
			orow_q      <= '0;
			odots_q     <= '0;
			osyms_q     <= '0;
			olast_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (lice_pkg::cfg_t'(cfg_index))
					lice_pkg::C_RULE_COUNT: rc_q <= cfg_data[5:0];
					lice_pkg::C_TERM_COUNT: tc_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// The read stage is registered from the issue counter, in the cycle after it.
			v_s1    <= iss_q;
			r_s1    <= ia_q[lice_pkg::ADDR_W-1:lice_pkg::DOT_W];
			d_s1    <= ia_q[lice_pkg::DOT_W-1:0];
			last_s1 <= last_iss;
			if (iss_q) begin
				ia_q <= ia_q + lice_pkg::ADDR_W'(1);
				if (last_iss) begin
					iss_q <= 1'b0;
				end
			end

			case (state_q)
				lice_pkg::S_IDLE: begin
					if (acc) begin
						func_q <= fin;
						gsym_q <= symbol;
						rk_q   <= lice_pkg::R_ACK;
						mask_q <= '0;
						mv_q   <= '0;
						ar_q   <= '0;
						chg_q  <= 1'b0;
						ia_q   <= '0;
						case (fin)
							lice_pkg::F_CLEAR: begin
								for (int r = 0; r < int'(lice_pkg::RULES); r++) begin
									rows_q[r] <= '0;
								end
							end
							lice_pkg::F_ADD: begin
								if ({1'b0, position} <= 5'(len_q[rule_index])) begin
									rows_q[rule_index] <= rows_q[rule_index]
									    | (lice_pkg::ROW_W'(1) << position);
								end
							end
							lice_pkg::F_INIT: begin
								for (int r = 0; r < int'(lice_pkg::RULES); r++) begin
									rows_q[r] <= ((lice_pkg::CNT_W'(r) < n) && (len_q[r] != '0))
									             ? lice_pkg::ROW_W'(1) : '0;
								end
							end
							lice_pkg::F_GOTO: begin
								// Rows beyond the rules in use are never walked, so clear them now.
								for (int r = 0; r < int'(lice_pkg::RULES); r++) begin
									if (lice_pkg::CNT_W'(r) >= n) begin
										rows_q[r] <= '0;
									end
								end
								iss_q <= (n != '0);
							end
							lice_pkg::F_CLOSE: begin
								iss_q <= (n != '0);
							end
							lice_pkg::F_QUERY: begin
								if (!readout_kind) begin
									rk_q  <= lice_pkg::R_MASK;
									iss_q <= (n != '0);
								end
							end
							default: ;
						endcase
					end
				end
				lice_pkg::S_WALK: begin
					mask_q <= mask_next;
					if (v_s1 && (func_q == lice_pkg::F_GOTO)) begin
						if (d_s1 == {lice_pkg::DOT_W{1'b1}}) begin
							rows_q[r_s1] <= mv_next;
							mv_q         <= '0;
						end else begin
							mv_q <= mv_next;
						end
					end
					if (v_s1 && last_s1) begin
						want_q <= want_next;
						ar_q   <= '0;
						chg_q  <= 1'b0;
					end
				end
				lice_pkg::S_ADD: begin
					// One row per cycle: add the dot-0 item of every wanted head.
					if (add_set) begin
						rows_q[ar_q] <= rows_q[ar_q] | lice_pkg::ROW_W'(1);
						chg_q        <= 1'b1;
					end
					ar_q <= ar_q + lice_pkg::RIDX_W'(1);
					if (ar_last && (chg_q || add_set)) begin
						mask_q <= '0;
						ia_q   <= '0;
						iss_q  <= 1'b1;
					end
				end
				lice_pkg::S_ROWS: begin
					if (out_free) begin
						okind_q     <= lice_pkg::R_ROW;
						orow_q      <= ar_q;
						odots_q     <= rows_q[ar_q];
						osyms_q     <= '0;
						olast_q     <= ar_last;
						ar_q        <= ar_q + lice_pkg::RIDX_W'(1);
					end
				end
				lice_pkg::S_REPLY: begin
					if (out_free) begin
						okind_q     <= rk_q;
						orow_q      <= '0;
						odots_q     <= '0;
						osyms_q     <= (rk_q == lice_pkg::R_MASK) ? mask_q : '0;
						olast_q     <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign reply_kind  = okind_q;
	assign row_rule    = orow_q;
	assign dot_mask    = odots_q;
	assign symbol_mask = osyms_q;
	assign last        = olast_q;

endmodule
